// ===== hw/rtl/xts_pkg.sv =====
// Package: item types, mode codes and XML character class functions
`timescale 1ns / 1ps

package xts_pkg;

	localparam int CpW = 21;

	localparam logic [2:0] MODE_NAME      = 3'd0;
	localparam logic [2:0] MODE_COMMENT   = 3'd1;
	localparam logic [2:0] MODE_PI_TARGET = 3'd2;
	localparam logic [2:0] MODE_PI_VALUE  = 3'd3;
	localparam logic [2:0] MODE_ATT_DQ    = 3'd4;
	localparam logic [2:0] MODE_ATT_SQ    = 3'd5;

	localparam logic [CpW-1:0] CH_DASH     = 21'h2D;
	localparam logic [CpW-1:0] CH_QUESTION = 21'h3F;
	localparam logic [CpW-1:0] CH_GT       = 21'h3E;
	localparam logic [CpW-1:0] CH_LT       = 21'h3C;
	localparam logic [CpW-1:0] CH_AMP      = 21'h26;
	localparam logic [CpW-1:0] CH_DQUOTE   = 21'h22;
	localparam logic [CpW-1:0] CH_SQUOTE   = 21'h27;

	localparam logic [2:0] COUNT_SAT = 3'd4;
	localparam logic [2:0] XML_LEN   = 3'd3;

	typedef struct packed {
		logic [2:0]     mode;
		logic [CpW-1:0] code_point;
		logic           decode_ok;
		logic           last_char;
		logic           empty_string;
	} in_item_t;

	typedef struct packed {
		logic string_valid;
	} out_item_t;

	function automatic logic name_start_ok(input logic [CpW-1:0] c);
		return c inside {21'h3A, 21'h5F, [21'h41:21'h5A], [21'h61:21'h7A],
			[21'hC0:21'hD6], [21'hD8:21'hF6], [21'hF8:21'h2FF], [21'h370:21'h37D],
			[21'h37F:21'h1FFF], [21'h200C:21'h200D], [21'h2070:21'h218F],
			[21'h2C00:21'h2FEF], [21'h3001:21'hD7FF], [21'hF900:21'hFDCF],
			[21'hFDF0:21'hFFFD], [21'h10000:21'hEFFFF]};
	endfunction

	function automatic logic name_rest_ok(input logic [CpW-1:0] c);
		return name_start_ok(c) || (c inside {21'h2D, 21'h2E, [21'h30:21'h39], 21'hB7,
			[21'h300:21'h36F], [21'h203F:21'h2040]});
	endfunction

	function automatic logic xml_char_ok(input logic [CpW-1:0] c);
		return c inside {21'h09, 21'h0A, 21'h0D, [21'h20:21'hD7FF],
			[21'hE000:21'hFFFD], [21'h10000:21'h10FFFF]};
	endfunction

	// match one letter of "xml" in either case at position idx
	function automatic logic xml_letter_ok(input logic [1:0] idx, input logic [CpW-1:0] c);
		logic ok;
		begin
			case (idx)
				2'd0: ok = (c == 21'h78) || (c == 21'h58);
				2'd1: ok = (c == 21'h6D) || (c == 21'h4D);
				2'd2: ok = (c == 21'h6C) || (c == 21'h4C);
				default: ok = 1'b0;
			endcase
			return ok;
		end
	endfunction

endpackage

// ===== hw/rtl/xts_if.sv =====
// Interfaces: valid/ready channels for character items and verdict items
`timescale 1ns / 1ps

interface xts_in_if import xts_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface xts_out_if import xts_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== hw/rtl/xml_token_string_validator.sv =====
// Top level: XML 1.0 name, comment, PI and attribute value string checker
//
//   channel  | dir | payload                                          | result
//   chars    | in  | mode, code_point, decode_ok, last_char, empty_str | -
//   verdict  | out | string_valid                                     | one per string
//
// One character item per cycle unless a string end waits on a full verdict slot.
// An accepted item is held in the input register, checked against the string state there
// and, on the last or empty item, loads the verdict register. arst_n clears string
// state and both valid flags. A stalled verdict holds the input register only when it
// also ends a string; other items keep flowing.
`timescale 1ns / 1ps

module xml_token_string_validator import xts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	xts_in_if.sink     chars,
	xts_out_if.source  verdict
);

	logic           valid_s1;
	in_item_t       item_s1;

	logic [2:0]     mode_q;
	logic           err_q;
	logic [2:0]     count_q;
	logic           dash_q;
	logic           quest_q;
	logic           prefix_q;

	logic           out_valid_q;
	out_item_t      out_item_q;

	logic           first;
	logic [2:0]     m;
	logic [CpW-1:0] cp;
	logic           err;
	logic           prefix_next;
	logic [2:0]     count_next;
	logic           final_err;
	logic           empty_ok;
	logic           ends;
	logic           advance;

	assign cp    = item_s1.code_point;
	assign first = (count_q == 3'd0);
	assign m     = first ? item_s1.mode : mode_q;
	assign ends  = item_s1.empty_string || item_s1.last_char;

	always_comb begin
		err = err_q || !item_s1.decode_ok;
		case (m)
			MODE_NAME:      err = err || (first ? !name_start_ok(cp) : !name_rest_ok(cp));
			MODE_COMMENT:   err = err || !xml_char_ok(cp) || (dash_q && cp == CH_DASH);
			MODE_PI_TARGET: err = err;
			MODE_PI_VALUE:  err = err || !xml_char_ok(cp) || (quest_q && cp == CH_GT);
			MODE_ATT_DQ:    err = err || cp == CH_LT || cp == CH_AMP || cp == CH_DQUOTE;
			MODE_ATT_SQ:    err = err || cp == CH_LT || cp == CH_AMP || cp == CH_SQUOTE;
			default:        err = 1'b1;
		endcase
	end

	always_comb begin
		prefix_next = prefix_q;
		if (count_q < XML_LEN && !xml_letter_ok(count_q[1:0], cp))
			prefix_next = 1'b0;
		count_next = (count_q < COUNT_SAT) ? count_q + 3'd1 : count_q;
	end

	assign final_err = err || (m == MODE_COMMENT && cp == CH_DASH) ||
		(m == MODE_PI_TARGET && count_next == XML_LEN && prefix_next);

	assign empty_ok = first && (item_s1.mode == MODE_COMMENT || item_s1.mode == MODE_PI_VALUE ||
		item_s1.mode == MODE_ATT_DQ || item_s1.mode == MODE_ATT_SQ);

	// advance unless the item ends a string and the verdict slot stays full
	assign advance     = valid_s1 && (!ends || !out_valid_q || verdict.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			item_s1 <= chars.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NAME;
			err_q    <= 1'b0;
			count_q  <= 3'd0;
			dash_q   <= 1'b0;
			quest_q  <= 1'b0;
			prefix_q <= 1'b1;
		end else if (advance) begin
			if (ends) begin
				mode_q   <= MODE_NAME;
				err_q    <= 1'b0;
				count_q  <= 3'd0;
				dash_q   <= 1'b0;
				quest_q  <= 1'b0;
				prefix_q <= 1'b1;
			end else begin
				mode_q   <= m;
				err_q    <= err;
				count_q  <= count_next;
				dash_q   <= (cp == CH_DASH);
				quest_q  <= (cp == CH_QUESTION);
				prefix_q <= prefix_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ends) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ends) begin
			out_item_q.string_valid <= item_s1.empty_string ? empty_ok : !final_err;
		end
	end

	assign verdict.valid = out_valid_q;
	assign verdict.item  = out_item_q;

endmodule
